// ===== hdl/bfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes, types and helpers for the frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int NFRAMES   = 4096;
  localparam int WORD_BITS = 32;
  localparam int NWORDS    = NFRAMES / WORD_BITS;
  localparam int WADDR_W   = $clog2(NWORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(NWORDS + 1);
  localparam int FRAME_W   = 12;
  localparam int CFG_W     = 13;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SKIP   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd2;

  typedef enum logic [2:0] {
    RES_SKIP,
    RES_NOFREE,
    RES_ALLOC,
    RES_FREE,
    RES_TEST
  } res_kind_e;

  typedef struct packed {
    logic      load_item;
    logic      rd_frame;
    logic      scan_clr;
    logic      scan_rd;
    logic      wr_alloc;
    logic      wr_free;
    logic      latch;
    logic      res_load;
    res_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            frame_zero;
    logic            no_words;
    logic            scan_more;
    logic            chk_vld;
    logic            word_full;
    logic            chk_last;
    logic            out_free;
  } dp_sts_t;

  // index of the lowest clear bit; only meaningful when one exists
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bfa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_in_if / bfa_out_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface bfa_in_if;
  import bfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FRAME_W-1:0] frame;
  logic               writable;
  logic               kernel_mode;

  modport source (output valid, output op, output frame, output writable,
                  output kernel_mode, input ready);
  modport sink   (input valid, input op, input frame, input writable,
                  input kernel_mode, output ready);
endinterface

interface bfa_out_if;
  import bfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [FRAME_W-1:0] frame_out;
  logic               present;
  logic               rw;
  logic               user;
  logic               in_use;

  modport source (output valid, output status, output frame_out, output present,
                  output rw, output user, output in_use, input ready);
  modport sink   (input valid, input status, input frame_out, input present,
                  input rw, input user, input in_use, output ready);
endinterface
`default_nettype wire

// ===== hdl/bfa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bfa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: decode, first-fit scan, read-modify-write, result hand-off.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bfa_pkg::dp_sts_t  sts_i,
  output bfa_pkg::dp_cmd_t       cmd_o
);
  import bfa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_WORD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  res_kind_e  kind_q, kind_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.kind = kind_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          OP_ALLOC: begin
            if (!sts_i.frame_zero) begin
              kind_d  = RES_SKIP;
              state_d = S_OUT;
            end else if (sts_i.no_words) begin
              kind_d  = RES_NOFREE;
              state_d = S_OUT;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d = S_SCAN;
            end
          end
          OP_FREE: begin
            if (sts_i.frame_zero) begin
              kind_d  = RES_SKIP;
              state_d = S_OUT;
            end else begin
              cmd_o.rd_frame = 1'b1;
              state_d = S_WORD;
            end
          end
          OP_TEST: begin
            cmd_o.rd_frame = 1'b1;
            state_d = S_WORD;
          end
          default: begin
            kind_d  = RES_SKIP;
            state_d = S_OUT;
          end
        endcase
      end
      S_WORD: begin
        cmd_o.latch = 1'b1;
        if (sts_i.op == OP_FREE) begin
          cmd_o.wr_free = 1'b1;
          kind_d = RES_FREE;
        end else begin
          kind_d = RES_TEST;
        end
        state_d = S_OUT;
      end
      S_SCAN: begin
        cmd_o.scan_rd = sts_i.scan_more;
        if (sts_i.chk_vld) begin
          if (!sts_i.word_full) begin
            cmd_o.wr_alloc = 1'b1;
            cmd_o.latch    = 1'b1;
            kind_d  = RES_ALLOC;
            state_d = S_OUT;
          end else if (sts_i.chk_last) begin
            kind_d  = RES_NOFREE;
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= RES_SKIP;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bfa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: item and config registers, bitmap RAM with word valid bits,
// scan pointers, bit search and the result register.
// ----------------------------------------------------------------------------
module bfa_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bfa_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic [bfa_pkg::OP_W-1:0]    op_i,
  input  wire logic [bfa_pkg::FRAME_W-1:0] frame_i,
  input  wire logic                        writable_i,
  input  wire logic                        kernel_mode_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic      [bfa_pkg::STAT_W-1:0]  status_o,
  output logic      [bfa_pkg::FRAME_W-1:0] frame_out_o,
  output logic                             present_o,
  output logic                             rw_o,
  output logic                             user_o,
  output logic                             in_use_o,
  input  wire bfa_pkg::dp_cmd_t            cmd_i,
  output bfa_pkg::dp_sts_t                 sts_o
);
  import bfa_pkg::*;

  logic [CFG_W-1:0]     fiu_q;
  logic [OP_W-1:0]      op_q;
  logic [FRAME_W-1:0]   frame_q;
  logic                 writable_q, kernel_q;
  logic [CNT_W-1:0]     rd_ptr_q;
  logic [WADDR_W-1:0]   chk_ptr_q;
  logic                 chk_vld_q;
  logic [NWORDS-1:0]    valid_q;
  logic                 rvld_q;
  logic [FRAME_W-1:0]   found_q;
  logic                 bit_q;
  logic                 out_valid_q;

  logic [CFG_W-BIT_W-1:0] words_raw;
  logic [CNT_W-1:0]       nwords;
  logic [WADDR_W-1:0]     frame_word;
  logic [BIT_W-1:0]       frame_bit;
  logic                   re;
  logic [WADDR_W-1:0]     raddr, waddr;
  logic [WORD_BITS-1:0]   rdata, word_eff, wdata;
  logic [BIT_W-1:0]       fz;
  logic                   we;

  logic [STAT_W-1:0]      status_d;
  logic [FRAME_W-1:0]     frame_out_d;
  logic                   present_d, rw_d, user_d, in_use_d;

  // whole words only, capped at the bitmap size
  assign words_raw  = fiu_q[CFG_W-1:BIT_W];
  assign nwords     = (words_raw > (CFG_W-BIT_W)'(NWORDS)) ? CNT_W'(NWORDS)
                                                           : CNT_W'(words_raw);
  assign frame_word = WADDR_W'(frame_q >> BIT_W);
  assign frame_bit  = frame_q[BIT_W-1:0];

  assign re    = cmd_i.rd_frame | cmd_i.scan_rd;
  assign raddr = cmd_i.rd_frame ? frame_word : rd_ptr_q[WADDR_W-1:0];

  // a word never written reads as all free
  assign word_eff = rvld_q ? rdata : '0;
  assign fz       = first_zero(word_eff);

  assign we    = cmd_i.wr_alloc | cmd_i.wr_free;
  assign waddr = cmd_i.wr_alloc ? chk_ptr_q : frame_word;
  assign wdata = cmd_i.wr_alloc ? (word_eff | (WORD_BITS'(1) << fz))
                                : (word_eff & ~(WORD_BITS'(1) << frame_bit));

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.op         = op_q;
    sts_o.frame_zero = (frame_q == '0);
    sts_o.no_words   = (nwords == '0);
    sts_o.scan_more  = (rd_ptr_q < nwords);
    sts_o.chk_vld    = chk_vld_q;
    sts_o.word_full  = &word_eff;
    sts_o.chk_last   = ((CNT_W'(chk_ptr_q) + CNT_W'(1)) == nwords);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // result word contents by kind
  always_comb begin
    status_d    = ST_DONE;
    frame_out_d = '0;
    present_d   = 1'b0;
    rw_d        = 1'b0;
    user_d      = 1'b0;
    in_use_d    = 1'b0;
    case (cmd_i.kind)
      RES_SKIP: begin
        status_d    = ST_SKIP;
        frame_out_d = frame_q;
      end
      RES_NOFREE: begin
        status_d = ST_NOFREE;
      end
      RES_ALLOC: begin
        frame_out_d = found_q;
        present_d   = 1'b1;
        rw_d        = writable_q;
        user_d      = !kernel_q;
      end
      RES_FREE: begin
        frame_out_d = '0;
      end
      RES_TEST: begin
        frame_out_d = frame_q;
        in_use_d    = bit_q;
      end
      default: begin
        status_d    = ST_SKIP;
        frame_out_d = frame_q;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q       <= CFG_RESET;
      valid_q     <= '0;
      chk_vld_q   <= 1'b0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fiu_q <= cfg_wdata_i;
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.scan_clr) begin
        rd_ptr_q  <= '0;
        chk_vld_q <= 1'b0;
      end else begin
        chk_vld_q <= cmd_i.scan_rd;
        if (cmd_i.scan_rd) begin
          rd_ptr_q <= rd_ptr_q + CNT_W'(1);
        end
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= op_i;
      frame_q    <= frame_i;
      writable_q <= writable_i;
      kernel_q   <= kernel_mode_i;
    end
    if (re) begin
      rvld_q <= valid_q[raddr];
    end
    if (cmd_i.scan_rd) begin
      chk_ptr_q <= rd_ptr_q[WADDR_W-1:0];
    end
    if (cmd_i.latch) begin
      found_q <= FRAME_W'({chk_ptr_q, fz});
      bit_q   <= word_eff[frame_bit];
    end
    if (cmd_i.res_load) begin
      status_o    <= status_d;
      frame_out_o <= frame_out_d;
      present_o   <= present_d;
      rw_o        <= rw_d;
      user_o      <= user_d;
      in_use_o    <= in_use_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/bitmap_frame_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit physical frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// Each request word carries one operation: allocate (lowest free frame,
// first fit), free (clear the frame's bit) or test (report the frame's bit).
// Exactly one result word comes back per request, in order. The bitmap is
// 128 words of 32 bits in a RAM; per-word valid flops make it read as all
// free straight after reset, so there is no clearing pass. A skipped
// request, or an allocate with no word to search, goes from decode
// straight to the output state; free and test first read the frame's
// bitmap word, and free writes it back with the bit cleared. An allocate
// scans from word 0 upward, one bitmap word per cycle through the RAM's
// single read port, until a word with a clear bit or the last searched
// word. A new request is taken the cycle after the previous one has
// handed its result to the output register, even while that result still
// waits to be taken; a stalled output holds the block until its result
// can be handed over.
// frames_in_use may only be written while the block is idle; values below 32
// mean no frame can be allocated.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  bfa_in_if.sink                         item_i,
  bfa_out_if.source                      result_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bfa_pkg::CFG_W-1:0] cfg_wdata_i
);
  import bfa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns the request handshake
  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: bitmap store, search and result word
  bfa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (item_i.op),
    .frame_i       (item_i.frame),
    .writable_i    (item_i.writable),
    .kernel_mode_i (item_i.kernel_mode),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .status_o      (result_o.status),
    .frame_out_o   (result_o.frame_out),
    .present_o     (result_o.present),
    .rw_o          (result_o.rw),
    .user_o        (result_o.user),
    .in_use_o      (result_o.in_use),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
`default_nettype wire

// ===== hdl/bfa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [bfa_pkg::STAT_W-1:0]  status_i,
  input wire logic [bfa_pkg::FRAME_W-1:0] frame_out_i,
  input wire logic                        present_i,
  input wire logic                        rw_i,
  input wire logic                        user_i,
  input wire logic                        in_use_i
);
  import bfa_pkg::*;

  // stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_DONE || status_i == ST_SKIP ||
                     status_i == ST_NOFREE))
    else $error("unknown status code");

  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_NOFREE |->
      frame_out_i == '0 && !present_i && !rw_i && !user_i && !in_use_i)
    else $error("no-free result carries data");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (rw_i || user_i) |-> present_i && status_i == ST_DONE)
    else $error("entry flags without present");

  a_inuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_use_i |-> status_i == ST_DONE && !present_i)
    else $error("in_use outside a test");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .status_i    (result_o.status),
  .frame_out_i (result_o.frame_out),
  .present_i   (result_o.present),
  .rw_i        (result_o.rw),
  .user_i      (result_o.user),
  .in_use_i    (result_o.in_use)
);
`default_nettype wire

// ===== bench/bitmap_frame_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_test
// Self-checking bench for the first-fit frame allocator. A local model of
// the bitmap predicts every result word. The result words are compared field
// by field, in order, under random sender gaps, receiver stalls, one long
// receiver hold-off and a sweep of the frames_in_use register.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_test;
  import bfa_pkg::*;

  // op 3 has no meaning; the block must skip it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES  = 12;
  // run-away limit, well above the slowest sane run
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 4;
  // longer than the slowest allocate from accept to result
  localparam int DRAIN_CYCLES  = 140;

  localparam logic [CFG_W-1:0] CFG_NONE  = CFG_W'(0);
  localparam logic [CFG_W-1:0] CFG_SHORT = CFG_W'(31);
  localparam logic [CFG_W-1:0] CFG_MIN   = CFG_W'(32);
  localparam logic [CFG_W-1:0] CFG_FULL  = CFG_W'(4096);
  localparam logic [CFG_W-1:0] CFG_MAX   = '1;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame_out;
    logic               present;
    logic               rw;
    logic               user;
    logic               in_use;
  } result_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CFG_W-1:0]   cfg_wdata_i;

  bfa_in_if  item_if ();
  bfa_out_if result_if ();

  bitmap_frame_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Local model of the allocator state
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] frame_map [NWORDS];
  logic [CFG_W-1:0]     managed_frames;
  result_word_t         expected_words [$];
  // frames handed out and not yet freed, used to build sensible free/test words
  logic [FRAME_W-1:0]   held_frames [$];
  int unsigned          fail_count;
  int unsigned          cycle_count;

  // sender pacing
  int                   burst_left;

  // receiver pacing
  logic                 long_hold_req;
  int                   hold_left;
  logic [7:0]           stall_pattern;
  int unsigned          stall_phase;

  // Works out the result word for one request and updates the model bitmap.
  function automatic result_word_t predict_allocator_word(
    input logic [OP_W-1:0]    op,
    input logic [FRAME_W-1:0] frame,
    input logic               writable,
    input logic               kernel_mode
  );
    result_word_t r;
    int unsigned  words;
    int           found;
    r           = '0;
    r.status    = ST_SKIP;
    r.frame_out = frame;
    case (op)
      OP_ALLOC: begin
        // a mapped entry is left alone
        if (frame == '0) begin
          // only whole words are searched, and never past the bitmap
          words = managed_frames / WORD_BITS;
          if (words > NWORDS) words = NWORDS;
          found = -1;
          for (int w = 0; w < words && found < 0; w++) begin
            if (frame_map[w] != '1) begin
              for (int b = 0; b < WORD_BITS && found < 0; b++) begin
                if (!frame_map[w][b]) found = w * WORD_BITS + b;
              end
            end
          end
          if (found < 0) begin
            r.status    = ST_NOFREE;
            r.frame_out = '0;
          end else begin
            frame_map[found / WORD_BITS][found % WORD_BITS] = 1'b1;
            r.status    = ST_DONE;
            r.frame_out = FRAME_W'(found);
            r.present   = 1'b1;
            r.rw        = writable;
            r.user      = !kernel_mode;
          end
        end
      end
      OP_FREE: begin
        // frame zero means nothing to free
        if (frame == '0) begin
          r.frame_out = '0;
        end else begin
          frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
          r.status    = ST_DONE;
          r.frame_out = '0;
        end
      end
      OP_TEST: begin
        r.status = ST_DONE;
        r.in_use = frame_map[frame / WORD_BITS][frame % WORD_BITS];
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one request word, then the burst/gap pacing
  // --------------------------------------------------------------------------
  task automatic send_word(
    input logic [OP_W-1:0]    op,
    input logic [FRAME_W-1:0] frame,
    input logic               writable,
    input logic               kernel_mode
  );
    result_word_t exp_word;
    int           gap;
    item_if.valid       <= 1'b1;
    item_if.op          <= op;
    item_if.frame       <= frame;
    item_if.writable    <= writable;
    item_if.kernel_mode <= kernel_mode;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    exp_word = predict_allocator_word(op, frame, writable, kernel_mode);
    expected_words.push_back(exp_word);
    // keep the list of held frames in step with the model
    if (op == OP_ALLOC && exp_word.status == ST_DONE && exp_word.frame_out != '0) begin
      held_frames.push_back(exp_word.frame_out);
    end else if (op == OP_FREE && exp_word.status == ST_DONE) begin
      for (int i = held_frames.size() - 1; i >= 0; i--) begin
        if (held_frames[i] == frame) held_frames.delete(i);
      end
    end
    // valid stays high inside a burst; a gap lowers it between bursts
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Lower valid and wait until every result word has been taken.
  task automatic wait_drained(input int extra);
    item_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // frames_in_use is only written with the block idle.
  task automatic set_frames_in_use(input logic [CFG_W-1:0] value);
    wait_drained(SETTLE_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    managed_frames = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random request. Mostly well-formed alloc/free/test traffic on the
  // frames actually held, with some mapped allocs, stray frees and op 3.
  task automatic send_random_word(input int alloc_pct);
    int                 pick;
    int                 idx;
    logic [FRAME_W-1:0] f;
    logic               wr;
    logic               km;
    wr   = $urandom_range(0, 1);
    km   = $urandom_range(0, 1);
    f    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      send_word(OP_ALLOC, '0, wr, km);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (held_frames.size() > 0) begin
          idx = $urandom_range(0, held_frames.size() - 1);
          send_word(OP_FREE, held_frames[idx], wr, km);
        end else begin
          send_word(OP_TEST, f, wr, km);
        end
      end else if (pick < 75) begin
        if (held_frames.size() > 0 && $urandom_range(0, 1) == 1) begin
          idx = $urandom_range(0, held_frames.size() - 1);
          f   = held_frames[idx];
        end
        send_word(OP_TEST, f, wr, km);
      end else if (pick < 83) begin
        send_word(OP_ALLOC, FRAME_W'($urandom_range(1, NFRAMES - 1)), wr, km);
      end else if (pick < 93) begin
        if ($urandom_range(0, 7) == 0) f = '0;
        send_word(OP_FREE, f, wr, km);
      end else begin
        send_word(OP_UNUSED, f, wr, km);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Bitmap reads as all free straight after reset.
  task automatic test_reset_state();
    send_word(OP_TEST, '0, 1'b0, 1'b0);
    send_word(OP_TEST, '1, 1'b1, 1'b1);
    send_word(OP_TEST, 12'hAAA, 1'b0, 1'b1);
  endtask

  // Every operation on the default pool, with the skip cases.
  task automatic test_entry_ops();
    send_word(OP_ALLOC, '0, 1'b1, 1'b0);      // lowest free is frame zero
    send_word(OP_ALLOC, '0, 1'b0, 1'b1);
    send_word(OP_ALLOC, '0, 1'b1, 1'b1);
    send_word(OP_ALLOC, '0, 1'b0, 1'b0);
    send_word(OP_ALLOC, '1, 1'b1, 1'b0);      // entry already mapped
    send_word(OP_ALLOC, 12'd1, 1'b0, 1'b1);
    send_word(OP_FREE, 12'd2, 1'b1, 1'b1);
    send_word(OP_FREE, '0, 1'b1, 1'b1);       // nothing to free
    send_word(OP_TEST, 12'd2, 1'b0, 1'b0);
    send_word(OP_TEST, '0, 1'b0, 1'b0);
    send_word(OP_FREE, '1, 1'b0, 1'b0);       // frame never handed out
    send_word(OP_TEST, '1, 1'b1, 1'b0);
    send_word(OP_ALLOC, '0, 1'b1, 1'b0);      // reuses the freed frame
    send_word(OP_UNUSED, '1, 1'b1, 1'b1);
    send_word(OP_UNUSED, '0, 1'b0, 1'b0);
  endtask

  // Register extremes: no word searched, short of one word, saturated, one word.
  task automatic test_pool_limits();
    set_frames_in_use(CFG_NONE);
    send_word(OP_ALLOC, '0, 1'b1, 1'b0);
    set_frames_in_use(CFG_SHORT);
    send_word(OP_ALLOC, '0, 1'b0, 1'b1);
    set_frames_in_use(CFG_MAX);
    send_word(OP_ALLOC, '0, 1'b1, 1'b1);
    set_frames_in_use(CFG_MIN);
    send_word(OP_ALLOC, '0, 1'b0, 1'b0);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block fills and must stall its input.
  task automatic test_long_stall();
    set_frames_in_use(CFG_FULL);
    long_hold_req <= 1'b1;
    repeat (30) send_random_word(60);
  endtask

  // Random traffic over a sweep of pool sizes; the small pools run dry.
  task automatic test_random_mix();
    logic [CFG_W-1:0] pool_cfg [9];
    int               pool_items [9];
    int               pool_alloc [9];
    pool_cfg   = '{CFG_MIN, CFG_W'(64), CFG_FULL, CFG_NONE, CFG_MAX, CFG_W'(160),
                   CFG_W'($urandom_range(32, 4096)), CFG_MIN, CFG_FULL};
    pool_items = '{120, 100, 230, 20, 150, 100, 100, 60, 40};
    pool_alloc = '{70, 60, 65, 50, 55, 60, 55, 70, 40};
    for (int p = 0; p < 9; p++) begin
      set_frames_in_use(pool_cfg[p]);
      repeat (pool_items[p]) send_random_word(pool_alloc[p]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_word_t exp_word;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, actual status %0d frame %0d",
                   $time, result_if.status, result_if.frame_out);
          fail_count++;
        end else begin
          exp_word = expected_words.pop_front();
          check_field("status",    exp_word.status,    result_if.status);
          check_field("frame_out", exp_word.frame_out, result_if.frame_out);
          check_field("present",   exp_word.present,   result_if.present);
          check_field("rw",        exp_word.rw,        result_if.rw);
          check_field("user",      exp_word.user,      result_if.user);
          check_field("in_use",    exp_word.in_use,    result_if.in_use);
        end
      end
      // long hold-off first, otherwise ready follows a repeating random stall pattern
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        stall_phase++;
        if (stall_phase % 64 == 0) begin
          stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        end
        result_if.ready <= stall_pattern[stall_phase % 8];
      end
    end
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    item_if.valid       = 1'b0;
    item_if.op          = OP_ALLOC;
    item_if.frame       = '0;
    item_if.writable    = 1'b0;
    item_if.kernel_mode = 1'b0;
    result_if.ready     = 1'b0;
    for (int w = 0; w < NWORDS; w++) frame_map[w] = '0;
    managed_frames = CFG_RESET;
    fail_count     = 0;
    cycle_count    = 0;
    burst_left     = 1;
    long_hold_req  = 1'b0;
    hold_left      = 0;
    stall_pattern  = 8'hFF;
    stall_phase    = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_entry_ops();
    test_pool_limits();
    test_long_stall();
    test_random_mix();

    // let the last words come out and watch for strays
    wait_drained(DRAIN_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
